### rtl/pedd_pkg.sv
`default_nettype none
// ============================================================================
// pedd_pkg
// Shared types, sizes and helpers for the palette error-diffusion ditherer.
// ============================================================================
package pedd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LIST_DEPTH = 32768;
    localparam int CELL_COUNT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LIST_W = $clog2(LIST_DEPTH);
    localparam int CELL_W = $clog2(CELL_COUNT);
    localparam int ERR_W  = 12;
    localparam int WANT_W = 14;

    localparam logic [1:0] CONV_GRAY   = 2'd0;
    localparam logic [1:0] CONV_DITHER = 2'd1;

    localparam logic [0:0] REG_CONV_MODE = 1'b0;
    localparam logic [0:0] REG_ROW_WIDTH = 1'b1;

    localparam logic [1:0]  CONV_MODE_RESET = 2'd1;
    localparam logic [11:0] ROW_WIDTH_RESET = 12'd512;

    typedef enum logic [1:0] {
        KIND_PAL   = 2'd0,
        KIND_CELL  = 2'd1,
        KIND_LIST  = 2'd2,
        KIND_PIXEL = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [14:0] address;
        logic [15:0] load_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_start;
    } item_t;

    typedef struct packed {
        logic [1:0]  conv_mode;
        logic [11:0] row_width;
    } cfg_t;

    function automatic logic signed [ERR_W-1:0] sat12(input logic signed [16:0] v);
        logic signed [ERR_W-1:0] res;
        if (v > 17'sd2047)
            res = 12'sd2047;
        else if (v < -17'sd2048)
            res = -12'sd2048;
        else
            res = v[ERR_W-1:0];
        return res;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [WANT_W-1:0] v);
        logic [7:0] res;
        if (v < 0)
            res = 8'd0;
        else if (v > 14'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/pedd_front.sv
`default_nettype none
// ============================================================================
// pedd_front
// Input stage: take words, tag their kind and hold them in a two-entry queue.
// ============================================================================
module pedd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     mode,
    input  wire logic [14:0]    address,
    input  wire logic [15:0]    load_value,
    input  wire logic [7:0]     red_in,
    input  wire logic [7:0]     green_in,
    input  wire logic [7:0]     blue_in,
    input  wire logic           frame_start,
    output logic                q_valid,
    output pedd_pkg::item_t     q_item,
    input  wire logic           q_pop
);
    import pedd_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      word_in;
    logic       push;
    logic       pop;

    always_comb
    begin
        word_in.kind        = kind_t'(mode);
        word_in.address     = address;
        word_in.load_value  = load_value;
        word_in.red         = red_in;
        word_in.green       = green_in;
        word_in.blue        = blue_in;
        word_in.frame_start = frame_start;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= word_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

### rtl/pedd_back.sv
`default_nettype none
// ============================================================================
// pedd_back
// Execution engine: store writes, luma, candidate scan and error diffusion.
// ============================================================================
module pedd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pedd_pkg::cfg_t cfg,
    input  wire logic           q_valid,
    input  wire pedd_pkg::item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          pixel_code
);
    import pedd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PIX, S_CELL, S_BASE, S_CNT, S_IDX, S_CMP,
        S_ERR0, S_ERR1, S_ERR2, S_OUT
    } state_t;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [WANT_W-1:0] want_t;

    // memories
    logic [23:0]         pal_mem  [256];
    logic [15:0]         cell_mem [CELL_COUNT];
    logic [7:0]          list_mem [LIST_DEPTH];
    logic [3*ERR_W-1:0]  row_mem  [MAX_WIDTH];
    logic [23:0]         pal_rdata_reg;
    logic [15:0]         cell_rdata_reg;
    logic [7:0]          list_rdata_reg;
    logic [3*ERR_W-1:0]  row_rdata_reg;

    logic                pal_we;
    logic                cell_we;
    logic                list_we;
    logic                row_we;
    logic [CELL_W-1:0]   cell_raddr;
    logic [LIST_W-1:0]   list_raddr;
    logic [COL_W-1:0]    row_raddr;
    logic [COL_W-1:0]    row_waddr;
    logic [3*ERR_W-1:0]  row_wdata;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                clr_pixel_reg, clr_pixel_next;
    item_t               item_reg, item_next;
    want_t               want_reg [3];
    want_t               want_next [3];
    err_t                right_reg [3];
    err_t                right_next [3];
    err_t                below_reg [3];
    err_t                below_next [3];
    logic signed [14:0]  e_reg [3];
    logic signed [14:0]  e_next [3];
    err_t                r_reg [3];
    err_t                r_next [3];
    logic [COL_W-1:0]    column_reg, column_next;
    logic [15:0]         base_reg, base_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          k_reg, k_next;
    logic [LIST_W-1:0]   ptr_reg, ptr_next;
    logic [7:0]          cand_reg, cand_next;
    logic [9:0]          bestd_reg, bestd_next;
    logic [23:0]         best_rgb_reg, best_rgb_next;
    logic [7:0]          code_reg, code_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          pixel_code_reg, pixel_code_next;

    // datapath
    logic [7:0]          pix [3];
    logic [7:0]          clamped [3];
    logic [7:0]          palc [3];
    logic [7:0]          bestc [3];
    logic [9:0]          cand_dist;
    logic [CELL_W-1:0]   cell_idx;
    logic [15:0]         luma;
    logic [COL_W-1:0]    nxt_col;
    logic [COL_W:0]      col_plus;
    logic signed [14:0]  e_calc [3];
    logic signed [16:0]  t3 [3];
    logic signed [16:0]  q8 [3];
    err_t                r_calc [3];
    err_t                rowc [3];
    err_t                rown [3];
    err_t                rowc_new [3];
    err_t                rown_new [3];

    always_comb
    begin
        logic signed [8:0] diff;
        pix[0] = item_reg.red;
        pix[1] = item_reg.green;
        pix[2] = item_reg.blue;
        cand_dist = 10'd0;
        for (int ch = 0; ch < 3; ch++)
        begin
            clamped[ch] = clamp8(want_reg[ch]);
            palc[ch]    = pal_rdata_reg[8*ch +: 8];
            bestc[ch]   = best_rgb_reg[8*ch +: 8];
            diff        = signed'({1'b0, clamped[ch]}) - signed'({1'b0, palc[ch]});
            cand_dist   = cand_dist + ((diff < 0) ? 10'(-diff) : 10'(diff));
            e_calc[ch]  = 15'(want_reg[ch]) - signed'({7'b0, bestc[ch]});
            t3[ch]      = (17'(e_calc[ch]) <<< 1) + 17'(e_calc[ch]);
            q8[ch]      = (t3[ch] + ((t3[ch] < 0) ? 17'sd7 : 17'sd0)) >>> 3;
            r_calc[ch]  = sat12(q8[ch]);
            rowc[ch]    = row_rdata_reg[ERR_W*ch +: ERR_W];
            rown[ch]    = row_rdata_reg[ERR_W*ch +: ERR_W];
            rowc_new[ch] = sat12(17'(rowc[ch]) + 17'(r_reg[ch]));
            rown_new[ch] = sat12(17'(e_reg[ch]) - (17'(r_reg[ch]) <<< 1));
        end
        cell_idx = {clamped[2][7:4], clamped[1][7:4], clamped[0][7:4]};
        luma = 16'({8'b0, item_reg.red}   * 16'd77)
             + 16'({8'b0, item_reg.green} * 16'd151)
             + 16'({8'b0, item_reg.blue}  * 16'd28);
        nxt_col  = column_reg + COL_W'(1);
        col_plus = {1'b0, column_reg} + (COL_W+1)'(1);
    end

    assign cell_raddr = cell_idx;
    assign row_raddr  = (state_reg == S_ERR0) ? column_reg : nxt_col;

    always_comb
    begin
        case (state_reg)
            S_BASE:  list_raddr = cell_rdata_reg[LIST_W-1:0];
            S_CNT:   list_raddr = base_reg[LIST_W-1:0] + LIST_W'(1);
            default: list_raddr = ptr_reg + LIST_W'(1);
        endcase
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[q_item.address[7:0]] <= {q_item.blue, q_item.green, q_item.red};
        pal_rdata_reg <= pal_mem[list_rdata_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[q_item.address[CELL_W-1:0]] <= q_item.load_value;
        cell_rdata_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[q_item.address[LIST_W-1:0]] <= q_item.load_value[7:0];
        list_rdata_reg <= list_mem[list_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        row_rdata_reg <= row_mem[row_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_pixel_next  = clr_pixel_reg;
        item_next       = item_reg;
        want_next       = want_reg;
        right_next      = right_reg;
        below_next      = below_reg;
        e_next          = e_reg;
        r_next          = r_reg;
        column_next     = column_reg;
        base_next       = base_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        ptr_next        = ptr_reg;
        cand_next       = cand_reg;
        bestd_next      = bestd_reg;
        best_rgb_next   = best_rgb_reg;
        code_next       = code_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_code_next = pixel_code_reg;
        q_pop           = 1'b0;
        pal_we          = 1'b0;
        cell_we         = 1'b0;
        list_we         = 1'b0;
        row_we          = 1'b0;
        row_waddr       = column_reg;
        row_wdata       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                row_we        = 1'b1;
                row_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                    state_next = clr_pixel_reg ? S_PIX : S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        KIND_PAL:  pal_we  = 1'b1;
                        KIND_CELL: cell_we = 1'b1;
                        KIND_LIST: list_we = 1'b1;
                        default:
                        begin
                            item_next = q_item;
                            if (q_item.frame_start)
                            begin
                                for (int ch = 0; ch < 3; ch++)
                                begin
                                    right_next[ch] = '0;
                                    below_next[ch] = '0;
                                end
                                column_next    = '0;
                                clr_addr_next  = '0;
                                clr_pixel_next = 1'b1;
                                state_next     = S_CLEAR;
                            end
                            else
                                state_next = S_PIX;
                        end
                    endcase
                end
            end
            S_PIX:
            begin
                if (cfg.conv_mode == CONV_GRAY)
                begin
                    code_next  = luma[15:8];
                    state_next = S_OUT;
                end
                else
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        want_next[ch] = signed'({6'b0, pix[ch]});
                        if (cfg.conv_mode == CONV_DITHER)
                            want_next[ch] = want_next[ch] + WANT_W'(right_reg[ch])
                                          + WANT_W'(below_reg[ch]);
                    end
                    state_next = S_CELL;
                end
            end
            S_CELL: state_next = S_BASE;
            S_BASE:
            begin
                base_next  = cell_rdata_reg;
                state_next = S_CNT;
            end
            S_CNT:
            begin
                count_next = list_rdata_reg;
                k_next     = 8'd0;
                ptr_next   = base_reg[LIST_W-1:0] + LIST_W'(1);
                state_next = S_IDX;
            end
            S_IDX:
            begin
                cand_next  = list_rdata_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (k_reg == 8'd0 || cand_dist < bestd_reg)
                begin
                    bestd_next    = cand_dist;
                    best_rgb_next = pal_rdata_reg;
                    code_next     = cand_reg;
                end
                if (({1'b0, k_reg} + 9'd1) < {1'b0, count_reg})
                begin
                    k_next     = k_reg + 8'd1;
                    ptr_next   = ptr_reg + LIST_W'(1);
                    state_next = S_IDX;
                end
                else
                    state_next = (cfg.conv_mode == CONV_DITHER) ? S_ERR0 : S_OUT;
            end
            S_ERR0:
            begin
                e_next     = e_calc;
                r_next     = r_calc;
                state_next = S_ERR1;
            end
            S_ERR1:
            begin
                row_we     = 1'b1;
                row_waddr  = column_reg;
                row_wdata  = {rowc_new[2], rowc_new[1], rowc_new[0]};
                state_next = S_ERR2;
            end
            S_ERR2:
            begin
                row_we     = 1'b1;
                row_waddr  = nxt_col;
                row_wdata  = {rown_new[2], rown_new[1], rown_new[0]};
                below_next = rown;
                right_next = r_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    pixel_code_next = code_reg;
                    if (col_plus >= {1'b0, cfg.row_width} || col_plus[COL_W])
                        column_next = '0;
                    else
                        column_next = col_plus[COL_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_pixel_reg  <= 1'b0;
            item_reg       <= '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                want_reg[ch]  <= '0;
                right_reg[ch] <= '0;
                below_reg[ch] <= '0;
                e_reg[ch]     <= '0;
                r_reg[ch]     <= '0;
            end
            column_reg     <= '0;
            base_reg       <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            ptr_reg        <= '0;
            cand_reg       <= '0;
            bestd_reg      <= '0;
            best_rgb_reg   <= '0;
            code_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pixel_code_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_pixel_reg  <= clr_pixel_next;
            item_reg       <= item_next;
            want_reg       <= want_next;
            right_reg      <= right_next;
            below_reg      <= below_next;
            e_reg          <= e_next;
            r_reg          <= r_next;
            column_reg     <= column_next;
            base_reg       <= base_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            ptr_reg        <= ptr_next;
            cand_reg       <= cand_next;
            bestd_reg      <= bestd_next;
            best_rgb_reg   <= best_rgb_next;
            code_reg       <= code_next;
            out_valid_reg  <= out_valid_next;
            pixel_code_reg <= pixel_code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_code = pixel_code_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped outside idle");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> row_we && row_wdata == '0 && !q_pop)
        else $error("row clear pass broken");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result word raised outside done state");

endmodule
`default_nettype wire

### rtl/palette_error_diffusion_dither_unit.sv
`default_nettype none
// ============================================================================
// palette_error_diffusion_dither_unit
// Palette ditherer: load words fill the stores, pixel words give one code.
// ============================================================================
// A load word is stored straight from idle. A pixel word in gray mode gives
// its luma code; otherwise the cell, list base and count are read, then each
// candidate of the list is compared, and dither mode adds the error steps.
// The scan rate is set by the list and palette memory read ports. A frame_start
// pixel first runs a sweep that zeroes the row error memory; the same sweep
// runs after reset, before any word; config resets to dither mode, width 512.
module palette_error_diffusion_dither_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [14:0] address,
    input  wire logic [15:0] load_value,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic        frame_start,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pixel_code
);
    import pedd_pkg::*;

    logic [1:0]  conv_mode_reg;
    logic [11:0] row_width_reg;
    logic        cfg_write;
    cfg_t        cfg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    // Registers are one word apart; bit 2 of the byte address picks them.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_ROW_WIDTH) ? {20'b0, row_width_reg}
                                                   : {30'b0, conv_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_mode_reg <= CONV_MODE_RESET;
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CONV_MODE)
                conv_mode_reg <= pwdata[1:0];
            else
                row_width_reg <= pwdata[11:0];
        end
    end

    assign cfg.conv_mode = conv_mode_reg;
    assign cfg.row_width = row_width_reg;

    // Front: tag and queue incoming words; input stalls once both slots are full.
    pedd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .address     (address),
        .load_value  (load_value),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .frame_start (frame_start),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // Back: execute stores, luma or candidate scan, diffuse error, hold the result.
    pedd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_code (pixel_code)
    );

endmodule
`default_nettype wire
